FILE: src/poc_pkg.sv
// shared constants of the particle overlap checker: field widths, commands, register map
package poc_pkg;

    // fixed payload field widths
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    // command codes on the request channel
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    // configuration port geometry
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    // register indexes (byte address is 4 times the index)
    localparam logic [REG_IDX_W-1:0] REG_BOX_X          = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_Y          = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_Z          = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PORE_CENTER_X  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PORE_CENTER_Y  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PORE_RADIUS    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_POLYMER_RADIUS = 3'd6;

    // kinds of entries that travel through the distance unit
    localparam logic [1:0] KIND_PART = 2'd0;
    localparam logic [1:0] KIND_ROD  = 2'd1;
    localparam logic [1:0] KIND_PORE = 2'd2;

endpackage

FILE: src/poc_req_if.sv
// request channel of the particle overlap checker: store or check commands
interface poc_req_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [poc_pkg::INDEX_W-1:0]  index;
    logic [COORD_BITS-1:0]        pos_x;
    logic [COORD_BITS-1:0]        pos_y;
    logic [COORD_BITS-1:0]        pos_z;
    logic [COORD_BITS-1:0]        radius;
    logic [poc_pkg::COUNT_W-1:0]  compare_count;

    modport source (
        output valid, cmd, index, pos_x, pos_y, pos_z, radius, compare_count,
        input  ready
    );

    modport sink (
        input  valid, cmd, index, pos_x, pos_y, pos_z, radius, compare_count,
        output ready
    );
endinterface

FILE: src/poc_rsp_if.sv
// response channel of the particle overlap checker: overlap flags per command
interface poc_rsp_if ();
    logic valid;
    logic ready;
    logic ion_overlap;
    logic rod_overlap;
    logic beyond_pore;
    logic was_write;

    modport source (
        output valid, ion_overlap, rod_overlap, beyond_pore, was_write,
        input  ready
    );

    modport sink (
        input  valid, ion_overlap, rod_overlap, beyond_pore, was_write,
        output ready
    );
endinterface

FILE: src/particle_overlap_checker_unit.sv
// hard-sphere overlap checker with periodic minimum image and a shared distance unit
//
//  channel | dir | transfer moves
//  --------+-----+-------------------------------------------------------------
//  req     | in  | store of one particle, or a trial position to check
//  rsp     | out | ion_overlap, rod_overlap, beyond_pore, was_write
//  apb     | in  | box lengths, pore center, pore radius, polymer radius
//
//  a store keeps req.ready low through the done state; the table is written at the transfer
//  a check keeps it low while min(compare_count, MAX_PARTICLES) entries are read, one table read
//  per cycle into the five-stage distance unit, then for the rod and pore entries and the drain
//  a finished response waits in its output register while the next request is taken; the
//  response after it holds in the done state, with req.ready low, until rsp drains
//  rst_n resets control and config registers; the particle table is not cleared
module particle_overlap_checker_unit #(
    parameter int MAX_PARTICLES = 1024,
    parameter int COORD_BITS    = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    poc_req_if.sink                      req,
    poc_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [poc_pkg::PADDR_W-1:0]  paddr,
    input  logic [poc_pkg::PDATA_W-1:0]  pwdata,
    output logic [poc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int C    = COORD_BITS;
    localparam int AW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW   = $clog2(MAX_PARTICLES + 1);
    localparam int SQW  = (2 * C + 2 > 64) ? 64 : 2 * C + 2;
    localparam int MW   = (C + 1 > 32) ? 32 : C + 1;
    localparam bit RS_SAT = (C + 1 > 32);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PART  = 3'd1;
    localparam logic [2:0] ST_ROD   = 3'd2;
    localparam logic [2:0] ST_PORE  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // configuration registers
    logic [C-1:0] box_x_reg, box_y_reg, box_z_reg;
    logic [C-1:0] pcx_reg, pcy_reg, pore_r_reg, poly_r_reg;

    // sequencer and trial latch
    logic [2:0]                  state_reg, state_next;
    logic [CW-1:0]               i_reg, i_next;
    logic [CW-1:0]               cnt_reg;
    logic [poc_pkg::INDEX_W-1:0] idx_reg;
    logic [C-1:0]                tx_reg, ty_reg, tz_reg, tr_reg;
    logic                        req_xfer;
    logic                        issue_v;
    logic [1:0]                  issue_kind;
    logic                        mem_re;
    logic                        mem_we;
    logic                        pipe_busy;
    logic                        rsp_load;

    // result flags and output register
    logic ion_reg, rod_reg, beyond_reg, wr_reg;
    logic rsp_valid_reg, rsp_ion_reg, rsp_rod_reg, rsp_beyond_reg, rsp_wr_reg;

    // particle table and its read register
    logic [4*C-1:0] part_mem [MAX_PARTICLES];
    logic [4*C-1:0] mem_q_reg;

    // distance unit pipeline
    logic                p0_v_reg, s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [1:0]          p0_kind_reg, s1_kind_reg, s2_kind_reg, s3_kind_reg, s4_kind_reg;
    logic [C-1:0]        ax, ay, az, ar, bx, by, bz, br;
    logic                wrap_en;
    logic signed [C:0]   s1_dx_next, s1_dy_next, s1_dz_next;
    logic [C:0]          s1_rs_next;
    logic signed [C:0]   s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic [C:0]          s1_rs_reg;
    logic                s1_wrap_reg;
    logic [C-1:0]        s2_mx_reg, s2_my_reg, s2_mz_reg;
    logic [C:0]          s2_rs_reg;
    logic [2*C-1:0]      sqx_next, sqy_next, sqz_next;
    logic [MW-1:0]       rs_m;
    logic [2*MW-1:0]     rsq_next;
    logic                rs_big;
    logic [SQW-1:0]      s3_sx_reg, s3_sy_reg, s3_sz_reg, s3_lim_reg;
    logic [SQW-1:0]      s4_sxy_next;
    logic [SQW-1:0]      s4_sxy_reg, s4_sz_reg, s4_lim_reg;
    logic [SQW-1:0]      d2_next;
    logic                hit_next;

    // wrapped difference magnitude along one axis
    function automatic logic [C-1:0] wrap_mag(input logic signed [C:0] d,
                                              input logic [C-1:0] len,
                                              input logic en);
        logic signed [C+2:0] de;
        logic signed [C+2:0] le;
        logic signed [C+2:0] tw;
        logic signed [C+2:0] w;
        logic signed [C+2:0] m;
        de = {{2{d[C]}}, d};
        le = {3'b000, len};
        tw = de <<< 1;
        if (en && (tw >= le))
            w = de - le;
        else if (en && (tw < -le))
            w = de + le;
        else
            w = de;
        m = w[C+2] ? -w : w;
        return m[C-1:0];
    endfunction

    // saturating add in the square domain
    function automatic logic [SQW-1:0] sat_add(input logic [SQW-1:0] a,
                                               input logic [SQW-1:0] b);
        logic [SQW:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[SQW] ? {SQW{1'b1}} : t[SQW-1:0];
    endfunction

    // apb port
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[poc_pkg::PADDR_W-1:2])
            poc_pkg::REG_BOX_X:          prdata = 32'(box_x_reg);
            poc_pkg::REG_BOX_Y:          prdata = 32'(box_y_reg);
            poc_pkg::REG_BOX_Z:          prdata = 32'(box_z_reg);
            poc_pkg::REG_PORE_CENTER_X:  prdata = 32'(pcx_reg);
            poc_pkg::REG_PORE_CENTER_Y:  prdata = 32'(pcy_reg);
            poc_pkg::REG_PORE_RADIUS:    prdata = 32'(pore_r_reg);
            poc_pkg::REG_POLYMER_RADIUS: prdata = 32'(poly_r_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg  <= C'(32'd65535);
            box_y_reg  <= C'(32'd65535);
            box_z_reg  <= C'(32'd65535);
            pcx_reg    <= C'(32'd32768);
            pcy_reg    <= C'(32'd32768);
            pore_r_reg <= '0;
            poly_r_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[poc_pkg::PADDR_W-1:2])
                poc_pkg::REG_BOX_X:          box_x_reg  <= C'(pwdata);
                poc_pkg::REG_BOX_Y:          box_y_reg  <= C'(pwdata);
                poc_pkg::REG_BOX_Z:          box_z_reg  <= C'(pwdata);
                poc_pkg::REG_PORE_CENTER_X:  pcx_reg    <= C'(pwdata);
                poc_pkg::REG_PORE_CENTER_Y:  pcy_reg    <= C'(pwdata);
                poc_pkg::REG_PORE_RADIUS:    pore_r_reg <= C'(pwdata);
                poc_pkg::REG_POLYMER_RADIUS: poly_r_reg <= C'(pwdata);
                default:                     ;
            endcase
        end
    end

    // request handshake
    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign mem_we    = req_xfer && (req.cmd == poc_pkg::CMD_STORE)
                       && (32'(req.index) < 32'(MAX_PARTICLES));

    assign pipe_busy = p0_v_reg || s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg;
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        issue_v    = 1'b0;
        issue_kind = poc_pkg::KIND_PART;
        mem_re     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    i_next = '0;
                    if (req.cmd == poc_pkg::CMD_CHECK)
                        state_next = ST_PART;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_PART:
            begin
                if (i_reg < cnt_reg)
                begin
                    mem_re  = 1'b1;
                    issue_v = (32'(i_reg) != 32'(idx_reg));
                    i_next  = i_reg + 1'b1;
                end
                else
                    state_next = ST_ROD;
            end
            ST_ROD:
            begin
                issue_v    = 1'b1;
                issue_kind = poc_pkg::KIND_ROD;
                state_next = ST_PORE;
            end
            ST_PORE:
            begin
                issue_v    = 1'b1;
                issue_kind = poc_pkg::KIND_PORE;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
        end
    end

    // trial latch at request transfer
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            tx_reg  <= req.pos_x;
            ty_reg  <= req.pos_y;
            tz_reg  <= req.pos_z;
            tr_reg  <= req.radius;
            idx_reg <= req.index;
            if (32'(req.compare_count) > 32'(MAX_PARTICLES))
                cnt_reg <= CW'(MAX_PARTICLES);
            else
                cnt_reg <= CW'(req.compare_count);
        end
    end

    // particle table: write on store, registered read during the walk
    always_ff @(posedge clk)
    begin
        if (mem_we)
            part_mem[AW'(req.index)] <= {req.pos_x, req.pos_y, req.pos_z, req.radius};
        if (mem_re)
            mem_q_reg <= part_mem[i_reg[AW-1:0]];
    end

    // operand select into the distance unit
    always_comb
    begin
        case (p0_kind_reg)
            poc_pkg::KIND_ROD:
            begin
                ax = pcx_reg;  ay = pcy_reg;  az = '0;     ar = poly_r_reg;
                bx = tx_reg;   by = ty_reg;   bz = '0;     br = tr_reg;
                wrap_en = 1'b1;
            end
            poc_pkg::KIND_PORE:
            begin
                ax = pcx_reg;  ay = pcy_reg;  az = '0;     ar = pore_r_reg;
                bx = tx_reg;   by = ty_reg;   bz = '0;     br = '0;
                wrap_en = 1'b0;
            end
            default:
            begin
                ax = mem_q_reg[4*C-1:3*C];
                ay = mem_q_reg[3*C-1:2*C];
                az = mem_q_reg[2*C-1:C];
                ar = mem_q_reg[C-1:0];
                bx = tx_reg;   by = ty_reg;   bz = tz_reg; br = tr_reg;
                wrap_en = 1'b1;
            end
        endcase
    end

    // stage 1: raw differences and radius sum
    assign s1_dx_next = $signed({1'b0, ax}) - $signed({1'b0, bx});
    assign s1_dy_next = $signed({1'b0, ay}) - $signed({1'b0, by});
    assign s1_dz_next = $signed({1'b0, az}) - $signed({1'b0, bz});
    assign s1_rs_next = {1'b0, ar} + {1'b0, br};

    // stage 3: squares on the shared multipliers
    assign sqx_next = s2_mx_reg * s2_mx_reg;
    assign sqy_next = s2_my_reg * s2_my_reg;
    assign sqz_next = s2_mz_reg * s2_mz_reg;
    assign rs_m     = MW'(s2_rs_reg);
    assign rsq_next = rs_m * rs_m;
    assign rs_big   = RS_SAT ? s2_rs_reg[C] : 1'b0;

    // stages 4 and 5: saturating sums and the compare
    assign s4_sxy_next = sat_add(s3_sx_reg, s3_sy_reg);
    assign d2_next     = sat_add(s4_sxy_reg, s4_sz_reg);
    assign hit_next    = (d2_next < s4_lim_reg);

    // pipeline valid and kind tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg    <= 1'b0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            p0_kind_reg <= poc_pkg::KIND_PART;
            s1_kind_reg <= poc_pkg::KIND_PART;
            s2_kind_reg <= poc_pkg::KIND_PART;
            s3_kind_reg <= poc_pkg::KIND_PART;
            s4_kind_reg <= poc_pkg::KIND_PART;
        end
        else
        begin
            p0_v_reg    <= issue_v;
            s1_v_reg    <= p0_v_reg;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            p0_kind_reg <= issue_kind;
            s1_kind_reg <= p0_kind_reg;
            s2_kind_reg <= s1_kind_reg;
            s3_kind_reg <= s2_kind_reg;
            s4_kind_reg <= s3_kind_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= s1_dx_next;
        s1_dy_reg   <= s1_dy_next;
        s1_dz_reg   <= s1_dz_next;
        s1_rs_reg   <= s1_rs_next;
        s1_wrap_reg <= wrap_en;
        s2_mx_reg   <= wrap_mag(s1_dx_reg, box_x_reg, s1_wrap_reg);
        s2_my_reg   <= wrap_mag(s1_dy_reg, box_y_reg, s1_wrap_reg);
        s2_mz_reg   <= wrap_mag(s1_dz_reg, box_z_reg, s1_wrap_reg);
        s2_rs_reg   <= s1_rs_reg;
        s3_sx_reg   <= SQW'(sqx_next);
        s3_sy_reg   <= SQW'(sqy_next);
        s3_sz_reg   <= SQW'(sqz_next);
        s3_lim_reg  <= rs_big ? {SQW{1'b1}} : SQW'(rsq_next);
        s4_sxy_reg  <= s4_sxy_next;
        s4_sz_reg   <= s3_sz_reg;
        s4_lim_reg  <= s3_lim_reg;
    end

    // result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ion_reg    <= 1'b0;
            rod_reg    <= 1'b0;
            beyond_reg <= 1'b0;
            wr_reg     <= 1'b0;
        end
        else if (req_xfer)
        begin
            ion_reg    <= 1'b0;
            rod_reg    <= 1'b0;
            beyond_reg <= 1'b0;
            wr_reg     <= (req.cmd == poc_pkg::CMD_STORE);
        end
        else if (s4_v_reg)
        begin
            case (s4_kind_reg)
                poc_pkg::KIND_PART: ion_reg    <= ion_reg | hit_next;
                poc_pkg::KIND_ROD:  rod_reg    <= hit_next;
                poc_pkg::KIND_PORE: beyond_reg <= !hit_next;
                default:            ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_ion_reg    <= ion_reg;
            rsp_rod_reg    <= rod_reg;
            rsp_beyond_reg <= beyond_reg;
            rsp_wr_reg     <= wr_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ion_overlap = rsp_ion_reg;
    assign rsp.rod_overlap = rsp_rod_reg;
    assign rsp.beyond_pore = rsp_beyond_reg;
    assign rsp.was_write   = rsp_wr_reg;

    // a response only appears out of the done state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside done state");

    // the distance unit is empty whenever a new request can be taken
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("distance unit busy while idle");

    // a store acknowledgment carries no overlap flags
    a_store_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_wr_reg) |-> !(rsp_ion_reg || rsp_rod_reg || rsp_beyond_reg))
        else $error("store response with overlap flags");

    // the walk never passes the compare count
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PART) |-> (i_reg <= cnt_reg))
        else $error("table walk beyond compare count");

endmodule

FILE: verif/overlap_flag_checker.sv
// checker for the particle overlap checker: watches req, rsp and apb, predicts and compares flags
`timescale 1ns / 1ps
module overlap_flag_checker #(
    parameter int SLOTS   = 1024,
    parameter int COORD_W = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    poc_req_if                           req,
    poc_rsp_if                           rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [poc_pkg::PADDR_W-1:0]  paddr,
    input  logic [poc_pkg::PDATA_W-1:0]  pwdata,
    output int                           pending,
    output int                           errors
);

    localparam longint unsigned CLIP = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic ion_overlap;
        logic rod_overlap;
        logic beyond_pore;
        logic was_write;
    } overlap_flags_t;

    // own copy of the particle table and the geometry registers
    logic [COORD_W-1:0] tab_x [SLOTS];
    logic [COORD_W-1:0] tab_y [SLOTS];
    logic [COORD_W-1:0] tab_z [SLOTS];
    logic [COORD_W-1:0] tab_r [SLOTS];
    logic [COORD_W-1:0] box_len_x, box_len_y, box_len_z;
    logic [COORD_W-1:0] axis_x, axis_y;
    logic [COORD_W-1:0] pore_rad, rod_rad;

    overlap_flags_t flags_due [$];
    int fail_count = 0;

    assign errors = fail_count;

    // minimum image along one axis, one correction only
    function automatic longint image_delta(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                           logic [COORD_W-1:0] len);
        longint d;
        longint l;
        d = longint'(a) - longint'(b);
        l = longint'(len);
        if (2 * d >= l)
            d = d - l;
        else if (2 * d < -l)
            d = d + l;
        return d;
    endfunction

    function automatic longint unsigned square_clip(longint d);
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : d;
        if (m > 64'hFFFF_FFFF)
            return CLIP;
        return m * m;
    endfunction

    function automatic longint unsigned sum_clip(longint unsigned a, longint unsigned b);
        return (a > CLIP - b) ? CLIP : a + b;
    endfunction

    // flags for one trial position against table, rod and pore
    function automatic overlap_flags_t check_flags(logic [poc_pkg::INDEX_W-1:0] skip,
                                                   logic [COORD_W-1:0] px,
                                                   logic [COORD_W-1:0] py,
                                                   logic [COORD_W-1:0] pz,
                                                   logic [COORD_W-1:0] rad,
                                                   logic [poc_pkg::COUNT_W-1:0] cnt);
        overlap_flags_t f;
        longint unsigned d2;
        longint unsigned lim;
        int n;
        f = '0;
        n = (int'(cnt) > SLOTS) ? SLOTS : int'(cnt);
        for (int i = 0; i < n && !f.ion_overlap; i++) begin
            if (i != int'(skip)) begin
                d2 = sum_clip(square_clip(image_delta(tab_x[i], px, box_len_x)),
                              square_clip(image_delta(tab_y[i], py, box_len_y)));
                d2 = sum_clip(d2, square_clip(image_delta(tab_z[i], pz, box_len_z)));
                lim = square_clip(longint'(tab_r[i]) + longint'(rad));
                if (d2 < lim)
                    f.ion_overlap = 1'b1;
            end
        end
        d2 = sum_clip(square_clip(image_delta(axis_x, px, box_len_x)),
                      square_clip(image_delta(axis_y, py, box_len_y)));
        f.rod_overlap = d2 < square_clip(longint'(rad) + longint'(rod_rad));
        // pore distance has no periodic wrap
        d2 = sum_clip(square_clip(longint'(axis_x) - longint'(px)),
                      square_clip(longint'(axis_y) - longint'(py)));
        f.beyond_pore = !(d2 < square_clip(longint'(pore_rad)));
        return f;
    endfunction

    task automatic log_mismatch(string why, overlap_flags_t want, overlap_flags_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t %s: expected ion=%b rod=%b pore=%b wr=%b, got ion=%b rod=%b pore=%b wr=%b",
                     $realtime, why, want.ion_overlap, want.rod_overlap, want.beyond_pore,
                     want.was_write, got.ion_overlap, got.rod_overlap, got.beyond_pore,
                     got.was_write);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        overlap_flags_t got;
        overlap_flags_t want;
        if (!rst_n)
        begin
            box_len_x <= 16'd65535;
            box_len_y <= 16'd65535;
            box_len_z <= 16'd65535;
            axis_x    <= 16'd32768;
            axis_y    <= 16'd32768;
            pore_rad  <= '0;
            rod_rad   <= '0;
            pending   <= 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[poc_pkg::PADDR_W-1:2])
                    poc_pkg::REG_BOX_X:          box_len_x <= pwdata[COORD_W-1:0];
                    poc_pkg::REG_BOX_Y:          box_len_y <= pwdata[COORD_W-1:0];
                    poc_pkg::REG_BOX_Z:          box_len_z <= pwdata[COORD_W-1:0];
                    poc_pkg::REG_PORE_CENTER_X:  axis_x    <= pwdata[COORD_W-1:0];
                    poc_pkg::REG_PORE_CENTER_Y:  axis_y    <= pwdata[COORD_W-1:0];
                    poc_pkg::REG_PORE_RADIUS:    pore_rad  <= pwdata[COORD_W-1:0];
                    poc_pkg::REG_POLYMER_RADIUS: rod_rad   <= pwdata[COORD_W-1:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest expectation
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.ion_overlap, rsp.rod_overlap, rsp.beyond_pore, rsp.was_write};
                if (flags_due.size() == 0)
                    log_mismatch("result with nothing expected", '0, got);
                else
                begin
                    want = flags_due.pop_front();
                    if (got !== want)
                        log_mismatch("flag mismatch", want, got);
                end
            end

            // request transfer: store updates the table, check is predicted
            if (req.valid && req.ready)
            begin
                if (req.cmd == poc_pkg::CMD_STORE)
                begin
                    tab_x[req.index] = req.pos_x;
                    tab_y[req.index] = req.pos_y;
                    tab_z[req.index] = req.pos_z;
                    tab_r[req.index] = req.radius;
                    want = '0;
                    want.was_write = 1'b1;
                end
                else
                    want = check_flags(req.index, req.pos_x, req.pos_y, req.pos_z,
                                       req.radius, req.compare_count);
                flags_due.push_back(want);
            end
            pending <= flags_due.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
// stimulus, handshake pacing and verdict for the particle overlap checker unit
`timescale 1ns / 1ps
module tb_top;

    localparam int SLOTS        = 1024;
    localparam int COORD_W      = 16;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 110;
    localparam int LAST_ITEMS   = 120;

    typedef struct {
        int unsigned bx;
        int unsigned by;
        int unsigned bz;
        int unsigned cx;
        int unsigned cy;
        int unsigned pore_r;
        int unsigned rod_r;
        int unsigned spread;
    } geometry_t;

    typedef enum {RX_EAGER, RX_COIN, RX_SLOW, RX_TOGGLE} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel, penable, pwrite, pready;
    logic [poc_pkg::PADDR_W-1:0] paddr;
    logic [poc_pkg::PDATA_W-1:0] pwdata, prdata;
    int pending;
    int errors;

    int burst_left;
    bit slot_written [SLOTS];
    int written_prefix;
    geometry_t geo;

    poc_req_if #(.COORD_BITS(COORD_W)) req_ch ();
    poc_rsp_if rsp_ch ();

    particle_overlap_checker_unit #(
        .MAX_PARTICLES(SLOTS),
        .COORD_BITS(COORD_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    overlap_flag_checker #(
        .SLOTS(SLOTS),
        .COORD_W(COORD_W)
    ) flag_check (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .pending(pending),
        .errors(errors)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // geometry settings, extremes included
    function automatic geometry_t setup_of(int p);
        case (p)
            0:       return '{4096, 4096, 0, 2048, 2048, 1024, 256, 512};
            1:       return '{65535, 65535, 65535, 32768, 32768, 8000, 2000, 6000};
            2:       return '{1, 1, 1, 0, 0, 0, 0, 64};
            3:       return '{3000, 65535, 500, 65535, 65535, 65535, 65535, 3000};
            4:       return '{0, 0, 0, 1000, 60000, 20000, 500, 2500};
            default: return '{8192, 8192, 8192, 4096, 4096, 3000, 800, 1500};
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(int unsigned len, int unsigned centre);
        int unsigned offset;
        offset = $urandom_range(0, 2 * geo.spread);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return (len == 0) ? '0 : COORD_W'(len - 1);
            3, 4:    return (len == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, len - 1));
            5:       return COORD_W'($urandom);
            default: return COORD_W'(centre + offset - geo.spread);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_radius();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COORD_W'($urandom);
            default: return COORD_W'($urandom_range(0, geo.spread / 2 + 1));
        endcase
    endfunction

    // bursts of back-to-back transfers separated by random gaps
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic push_request(logic cmd, logic [poc_pkg::INDEX_W-1:0] idx,
                                logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [COORD_W-1:0] z, logic [COORD_W-1:0] rad,
                                logic [poc_pkg::COUNT_W-1:0] cnt);
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.index         <= idx;
        req_ch.pos_x         <= x;
        req_ch.pos_y         <= y;
        req_ch.pos_z         <= z;
        req_ch.radius        <= rad;
        req_ch.compare_count <= cnt;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        // track which leading slots hold data so checks never read an empty slot
        if (cmd == poc_pkg::CMD_STORE)
            slot_written[idx] = 1'b1;
        while (written_prefix < SLOTS && slot_written[written_prefix])
            written_prefix++;
        pace_sender();
    endtask

    // setup and access phase of one write; the caller releases the bus after the last one
    task automatic write_cfg(logic [poc_pkg::REG_IDX_W-1:0] ridx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= {16'($urandom), 16'(value)};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_setup(int p);
        wait_idle();
        geo = setup_of(p);
        write_cfg(poc_pkg::REG_BOX_X, geo.bx);
        write_cfg(poc_pkg::REG_BOX_Y, geo.by);
        write_cfg(poc_pkg::REG_BOX_Z, geo.bz);
        write_cfg(poc_pkg::REG_PORE_CENTER_X, geo.cx);
        write_cfg(poc_pkg::REG_PORE_CENTER_Y, geo.cy);
        write_cfg(poc_pkg::REG_PORE_RADIUS, geo.pore_r);
        write_cfg(poc_pkg::REG_POLYMER_RADIUS, geo.rod_r);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_item();
        int idx;
        int cnt;
        if ($urandom_range(0, 9) < 4)
        begin
            // stores mostly grow the written prefix, the rest land anywhere
            if (written_prefix < SLOTS && $urandom_range(0, 2) != 0)
                idx = written_prefix;
            else
                idx = $urandom_range(0, SLOTS - 1);
            cnt = $urandom_range(0, 2047);
            push_request(poc_pkg::CMD_STORE, idx[poc_pkg::INDEX_W-1:0],
                         rand_coord(geo.bx, geo.cx), rand_coord(geo.by, geo.cy),
                         rand_coord(geo.bz, geo.cx), rand_radius(),
                         cnt[poc_pkg::COUNT_W-1:0]);
        end
        else
        begin
            if (written_prefix == SLOTS)
                cnt = ($urandom_range(0, 11) == 0) ? $urandom_range(SLOTS, 2047)
                                                   : $urandom_range(0, 64);
            else
                cnt = $urandom_range(0, written_prefix);
            idx = $urandom_range(0, 1) ? $urandom_range(0, cnt) : $urandom_range(0, SLOTS - 1);
            push_request(poc_pkg::CMD_CHECK, idx[poc_pkg::INDEX_W-1:0],
                         rand_coord(geo.bx, geo.cx), rand_coord(geo.by, geo.cy),
                         rand_coord(geo.bz, geo.cx), rand_radius(),
                         cnt[poc_pkg::COUNT_W-1:0]);
        end
    endtask

    // receiver: changing stall pattern plus one long hold-off
    initial
    begin
        int rsp_seen;
        int hold_left;
        int mode_left;
        bit held;
        rx_mode_t mode;
        rsp_seen = 0;
        hold_left = 0;
        mode_left = 0;
        held = 1'b0;
        mode = RX_EAGER;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                rsp_seen++;
            if (!held && rsp_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_EAGER: rsp_ch.ready <= 1'b1;
                    RX_COIN:  rsp_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SLOW:  rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:  rsp_ch.ready <= ~rsp_ch.ready;
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel ||
                !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        req_ch.valid         <= 1'b0;
        req_ch.cmd           <= poc_pkg::CMD_STORE;
        req_ch.index         <= '0;
        req_ch.pos_x         <= '0;
        req_ch.pos_y         <= '0;
        req_ch.pos_z         <= '0;
        req_ch.radius        <= '0;
        req_ch.compare_count <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        burst_left = 1;
        written_prefix = 0;
        foreach (slot_written[s])
            slot_written[s] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: box 16.0 on x and y, no wrap on z
        load_setup(0);
        push_request(poc_pkg::CMD_STORE, 0, 100, 100, 100, 50, 0);
        push_request(poc_pkg::CMD_STORE, 1, 2148, 100, 100, 50, 0);
        push_request(poc_pkg::CMD_STORE, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        push_request(poc_pkg::CMD_STORE, 3, 0, 0, 0, 0, 0);
        push_request(poc_pkg::CMD_STORE, SLOTS - 1, 4095, 4095, 4095, 300, 11'h7FF);
        // exact touch is no overlap, one step closer is
        push_request(poc_pkg::CMD_CHECK, SLOTS - 1, 200, 100, 100, 50, 1);
        push_request(poc_pkg::CMD_CHECK, SLOTS - 1, 199, 100, 100, 50, 1);
        // skipped slot does not count
        push_request(poc_pkg::CMD_CHECK, 0, 199, 100, 100, 50, 1);
        // nothing compared
        push_request(poc_pkg::CMD_CHECK, SLOTS - 1, 100, 100, 100, 0, 0);
        // difference of plus half box wraps, minus half box does not
        push_request(poc_pkg::CMD_CHECK, 0, 100, 100, 100, 2000, 2);
        push_request(poc_pkg::CMD_CHECK, 0, 4196, 100, 100, 2000, 2);
        push_request(poc_pkg::CMD_CHECK, 0, 100, 100, 100, 2047, 2);
        // largest coordinates and radii
        push_request(poc_pkg::CMD_CHECK, SLOTS - 1, 0, 0, 0, 16'hFFFF, 4);
        push_request(poc_pkg::CMD_CHECK, SLOTS - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4);
        push_request(poc_pkg::CMD_CHECK, 3, 16'hFFFF, 16'hFFFF, 0, 0, 4);
        // rod and pore boundaries
        push_request(poc_pkg::CMD_CHECK, 0, 2048, 2048, 0, 0, 0);
        push_request(poc_pkg::CMD_CHECK, 0, 3072, 2048, 0, 0, 0);
        push_request(poc_pkg::CMD_CHECK, 0, 3071, 2048, 0, 0, 0);
        push_request(poc_pkg::CMD_CHECK, 0, 2304, 2048, 0, 0, 0);
        push_request(poc_pkg::CMD_CHECK, 0, 2303, 2048, 0, 0, 0);
        push_request(poc_pkg::CMD_CHECK, 0, 0, 0, 0, 10, 0);

        // random phases over several geometries
        for (int p = 1; p <= 4; p++)
        begin
            load_setup(p);
            repeat (PHASE_ITEMS) random_item();
        end

        // last geometry, table keeps growing from the written prefix
        load_setup(5);
        repeat (LAST_ITEMS) random_item();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
